// ===== rtl/ngw_pkg.sv =====
package ngw_pkg;

  localparam int GUIDE_DEPTH = 1024;
  localparam int SLOT_W      = 10;
  localparam int COUNT_W     = 11;
  localparam int COORD_W     = 24;
  localparam int GROUP_W     = 16;
  localparam int LIMIT_W     = 20;
  localparam int NEAREST     = 4;
  localparam int NCNT_W      = 3;
  localparam int D2_W        = 50;
  localparam int ROOT_W      = 25;
  localparam int NUM_W       = 57;
  localparam int DEN_W       = 43;
  localparam int RECIP_W     = 41;
  localparam int WEIGHT_W    = 17;
  localparam int RECIP_SHIFT = 40;
  localparam int MEM_W       = 3*COORD_W + GROUP_W;

  localparam logic [COUNT_W-1:0]  NO_SLOT    = 11'd1024;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [2:0] ST_WEIGHTED   = 3'd0;
  localparam logic [2:0] ST_OWN        = 3'd1;
  localparam logic [2:0] ST_COINCIDENT = 3'd2;
  localparam logic [2:0] ST_UNGUIDED   = 3'd3;
  localparam logic [2:0] ST_LOADED     = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;
  localparam logic [2:0] ST_CLEARED    = 3'd6;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [COORD_W-1:0] root_x;
    logic signed [COORD_W-1:0] root_y;
    logic signed [COORD_W-1:0] root_z;
    logic [GROUP_W-1:0]        group_id;
    logic                      is_guide;
    logic                      too_short;
    logic [SLOT_W-1:0]         own_slot;
  } in_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [COUNT_W-1:0]  slot_a;
    logic [COUNT_W-1:0]  slot_b;
    logic [COUNT_W-1:0]  slot_c;
    logic [COUNT_W-1:0]  slot_d;
    logic [WEIGHT_W-1:0] weight_a;
    logic [WEIGHT_W-1:0] weight_b;
    logic [WEIGHT_W-1:0] weight_c;
    logic [WEIGHT_W-1:0] weight_d;
    logic [2:0]          used_count;
  } out_t;

endpackage

// ===== rtl/nearest_guide_weighting_unit.sv =====
// clear, load and short-cut queries: the result is registered, then moves to the output register
// query: table scan at one memory read per cycle through the scan pipeline, then per kept guide
//   a set-up state, 25 square-root steps and 57 divide steps, then per weight a
//   set-up state and 57 divide steps
// one transaction is in work at a time; a finished result waits in the output register
// reset (synchronous, rst_n low): guide count, coincident limit and all control cleared,
//   table contents undefined until loaded
module nearest_guide_weighting_unit import ngw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_SPREP = 7'b0000100,
    S_SQRT  = 7'b0001000,
    S_RDIV  = 7'b0010000,
    S_WPREP = 7'b0100000,
    S_WDIV  = 7'b1000000
  } state_t;

  function automatic out_t empty_res(input logic [2:0] st);
    out_t r;
    r.status     = st;
    r.slot_a     = NO_SLOT;
    r.slot_b     = NO_SLOT;
    r.slot_c     = NO_SLOT;
    r.slot_d     = NO_SLOT;
    r.weight_a   = '0;
    r.weight_b   = '0;
    r.weight_c   = '0;
    r.weight_d   = '0;
    r.used_count = '0;
    return r;
  endfunction

  state_t state_r, state_nxt;
  logic fin_r, fin_nxt;
  out_t res_r, res_nxt;
  logic out_valid_r;
  out_t out_data_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic [MEM_W-1:0] mem [GUIDE_DEPTH];
  logic [MEM_W-1:0] rd_r;
  logic mem_wr, mem_rd;

  logic signed [COORD_W-1:0] qx_r, qy_r, qz_r;
  logic [GROUP_W-1:0] qg_r;
  logic [COUNT_W-1:0] scan_r, scan_nxt;
  logic v1_r, v2_r, v3_r, v4_r;
  logic [SLOT_W-1:0] s1_r, s2_r, s3_r, s4_r;
  logic [COORD_W-1:0] dx_r, dy_r, dz_r;
  logic [2*COORD_W-1:0] sx_r, sy_r, sz_r;
  logic [D2_W-1:0] d2_r;

  logic [D2_W-1:0] cd_r [NEAREST];
  logic [D2_W-1:0] cd_nxt [NEAREST];
  logic [SLOT_W-1:0] cs_r [NEAREST];
  logic [SLOT_W-1:0] cs_nxt [NEAREST];
  logic [NCNT_W-1:0] n_r, n_nxt;
  logic [NEAREST-1:0] ins_m;

  logic [1:0] k_r, k_nxt;
  logic k_last;
  logic [RECIP_W-1:0] recip_r [NEAREST];
  logic [RECIP_W-1:0] recip_nxt [NEAREST];
  logic [WEIGHT_W-1:0] w_r [NEAREST];
  logic [WEIGHT_W-1:0] w_nxt [NEAREST];
  logic [DEN_W-1:0] total_r, total_nxt;

  logic [D2_W-1:0] sq_src_r, sq_src_nxt;
  logic [ROOT_W+2:0] sq_rem_r, sq_rem_nxt, sq_t, sq_trial;
  logic [ROOT_W-1:0] sq_root_r, sq_root_nxt, sq_root_step;
  logic [4:0] sq_cnt_r, sq_cnt_nxt;

  logic [NUM_W-1:0] dv_num_r, dv_num_nxt, dv_q_r, dv_q_nxt, dv_q_step;
  logic [DEN_W-1:0] dv_den_r, dv_den_nxt;
  logic [DEN_W:0] dv_rem_r, dv_rem_nxt, dv_t;
  logic [5:0] dv_cnt_r, dv_cnt_nxt;

  logic acc, out_free;

  assign in_stall  = (state_r != S_IDLE) || fin_r;
  assign acc       = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign k_last    = ({1'b0, k_r} + NCNT_W'(1)) == n_r;

  // table memory
  assign mem_wr = acc && (in_data.command == CMD_ADD) && (count_r != COUNT_W'(GUIDE_DEPTH));
  assign mem_rd = (state_r == S_SCAN) && (scan_r < count_r);

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[count_r[SLOT_W-1:0]] <= {in_data.root_x, in_data.root_y, in_data.root_z,
                                   in_data.group_id};
    end
    if (mem_rd) begin
      rd_r <= mem[scan_r[SLOT_W-1:0]];
    end
  end

  // scan pipeline: read, diff, square, sum
  logic signed [COORD_W:0] ex, ey, ez;
  logic signed [COORD_W-1:0] gx, gy, gz;
  logic [GROUP_W-1:0] gg;
  always_comb begin
    {gx, gy, gz, gg} = rd_r;
    ex = {qx_r[COORD_W-1], qx_r} - {gx[COORD_W-1], gx};
    ey = {qy_r[COORD_W-1], qy_r} - {gy[COORD_W-1], gy};
    ez = {qz_r[COORD_W-1], qz_r} - {gz[COORD_W-1], gz};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= mem_rd;
      v2_r <= v1_r && (gg == qg_r);
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= scan_r[SLOT_W-1:0];
    s2_r <= s1_r;
    s3_r <= s2_r;
    s4_r <= s3_r;
    dx_r <= ex[COORD_W] ? COORD_W'(-ex) : ex[COORD_W-1:0];
    dy_r <= ey[COORD_W] ? COORD_W'(-ey) : ey[COORD_W-1:0];
    dz_r <= ez[COORD_W] ? COORD_W'(-ez) : ez[COORD_W-1:0];
    sx_r <= dx_r * dx_r;
    sy_r <= dy_r * dy_r;
    sz_r <= dz_r * dz_r;
    d2_r <= D2_W'(sx_r) + D2_W'(sy_r) + D2_W'(sz_r);
  end

  // sorted insertion, strict less-than keeps the lower slot on ties
  always_comb begin
    for (int i = 0; i < NEAREST; i++) begin
      ins_m[i] = (NCNT_W'(i) >= n_r) || (d2_r < cd_r[i]);
    end
  end

  // square root step
  always_comb begin
    sq_t         = {sq_rem_r[ROOT_W:0], sq_src_r[D2_W-1 -: 2]};
    sq_trial     = {1'b0, sq_root_r, 2'b01};
    sq_root_step = (sq_t >= sq_trial) ? {sq_root_r[ROOT_W-2:0], 1'b1}
                                      : {sq_root_r[ROOT_W-2:0], 1'b0};
  end

  // restoring divide step
  always_comb begin
    dv_t      = {dv_rem_r[DEN_W-1:0], dv_num_r[NUM_W-1]};
    dv_q_step = {dv_q_r[NUM_W-2:0], (dv_t >= {1'b0, dv_den_r})};
  end

  always_comb begin
    state_nxt   = state_r;
    fin_nxt     = fin_r;
    res_nxt     = res_r;
    count_nxt   = count_r;
    scan_nxt    = scan_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    total_nxt   = total_r;
    sq_src_nxt  = sq_src_r;
    sq_rem_nxt  = sq_rem_r;
    sq_root_nxt = sq_root_r;
    sq_cnt_nxt  = sq_cnt_r;
    dv_num_nxt  = dv_num_r;
    dv_q_nxt    = dv_q_r;
    dv_den_nxt  = dv_den_r;
    dv_rem_nxt  = dv_rem_r;
    dv_cnt_nxt  = dv_cnt_r;
    for (int i = 0; i < NEAREST; i++) begin
      cd_nxt[i]    = cd_r[i];
      cs_nxt[i]    = cs_r[i];
      recip_nxt[i] = recip_r[i];
      w_nxt[i]     = w_r[i];
    end

    if (fin_r && out_free) begin
      fin_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_data.command)
            CMD_CLEAR: begin
              count_nxt = '0;
              res_nxt   = empty_res(ST_CLEARED);
              fin_nxt   = 1'b1;
            end
            CMD_ADD: begin
              fin_nxt = 1'b1;
              if (count_r == COUNT_W'(GUIDE_DEPTH)) begin
                res_nxt = empty_res(ST_FULL);
              end else begin
                res_nxt        = empty_res(ST_LOADED);
                res_nxt.slot_a = count_r;
                count_nxt      = count_r + COUNT_W'(1);
              end
            end
            CMD_QUERY: begin
              if (in_data.too_short) begin
                res_nxt = empty_res(ST_UNGUIDED);
                fin_nxt = 1'b1;
              end else if (in_data.is_guide && ({1'b0, in_data.own_slot} < count_r)) begin
                res_nxt            = empty_res(ST_OWN);
                res_nxt.slot_a     = {1'b0, in_data.own_slot};
                res_nxt.weight_a   = WEIGHT_ONE;
                res_nxt.used_count = 3'd1;
                fin_nxt            = 1'b1;
              end else begin
                scan_nxt  = '0;
                n_nxt     = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (mem_rd) begin
          scan_nxt = scan_r + COUNT_W'(1);
        end
        if (v4_r && (|ins_m)) begin
          for (int j = 0; j < NEAREST; j++) begin
            if (ins_m[j]) begin
              if (j == 0 || !ins_m[(j == 0) ? 0 : j-1]) begin
                cd_nxt[j] = d2_r;
                cs_nxt[j] = s4_r;
              end else begin
                cd_nxt[j] = cd_r[(j == 0) ? 0 : j-1];
                cs_nxt[j] = cs_r[(j == 0) ? 0 : j-1];
              end
            end
          end
          if (n_r != NCNT_W'(NEAREST)) begin
            n_nxt = n_r + NCNT_W'(1);
          end
        end
        if (!mem_rd && !v1_r && !v2_r && !v3_r && !v4_r) begin
          if (n_r == '0) begin
            res_nxt   = empty_res(ST_UNGUIDED);
            fin_nxt   = 1'b1;
            state_nxt = S_IDLE;
          end else if (cd_r[0] <= D2_W'(limit_r)) begin
            res_nxt            = empty_res(ST_COINCIDENT);
            res_nxt.slot_a     = {1'b0, cs_r[0]};
            res_nxt.weight_a   = WEIGHT_ONE;
            res_nxt.used_count = 3'd1;
            fin_nxt            = 1'b1;
            state_nxt          = S_IDLE;
          end else begin
            k_nxt     = '0;
            total_nxt = '0;
            for (int i = 0; i < NEAREST; i++) begin
              w_nxt[i] = '0;
            end
            state_nxt = S_SPREP;
          end
        end
      end

      S_SPREP: begin
        sq_src_nxt  = cd_r[k_r];
        sq_rem_nxt  = '0;
        sq_root_nxt = '0;
        sq_cnt_nxt  = '0;
        state_nxt   = S_SQRT;
      end

      S_SQRT: begin
        sq_rem_nxt  = (sq_t >= sq_trial) ? (sq_t - sq_trial) : sq_t;
        sq_root_nxt = sq_root_step;
        sq_src_nxt  = {sq_src_r[D2_W-3:0], 2'b00};
        sq_cnt_nxt  = sq_cnt_r + 5'd1;
        if (sq_cnt_r == 5'(ROOT_W-1)) begin
          dv_num_nxt = NUM_W'(1) << RECIP_SHIFT;
          dv_den_nxt = (sq_root_step == '0) ? DEN_W'(1) : DEN_W'(sq_root_step);
          dv_rem_nxt = '0;
          dv_q_nxt   = '0;
          dv_cnt_nxt = '0;
          state_nxt  = S_RDIV;
        end
      end

      S_RDIV, S_WDIV: begin
        dv_rem_nxt = (dv_t >= {1'b0, dv_den_r}) ? (dv_t - {1'b0, dv_den_r}) : dv_t;
        dv_q_nxt   = dv_q_step;
        dv_num_nxt = {dv_num_r[NUM_W-2:0], 1'b0};
        dv_cnt_nxt = dv_cnt_r + 6'd1;
        if (dv_cnt_r == 6'(NUM_W-1)) begin
          if (state_r == S_RDIV) begin
            recip_nxt[k_r] = dv_q_step[RECIP_W-1:0];
            total_nxt      = total_r + DEN_W'(dv_q_step[RECIP_W-1:0]);
            if (k_last) begin
              k_nxt     = '0;
              state_nxt = S_WPREP;
            end else begin
              k_nxt     = k_r + 2'd1;
              state_nxt = S_SPREP;
            end
          end else begin
            w_nxt[k_r] = (dv_q_step > NUM_W'(WEIGHT_ONE)) ? WEIGHT_ONE
                                                          : dv_q_step[WEIGHT_W-1:0];
            if (k_last) begin
              res_nxt            = empty_res(ST_WEIGHTED);
              res_nxt.used_count = n_r;
              res_nxt.slot_a     = {1'b0, cs_r[0]};
              res_nxt.weight_a   = (k_r == 2'd0) ? w_nxt[k_r] : w_r[0];
              if (n_r > NCNT_W'(1)) begin
                res_nxt.slot_b   = {1'b0, cs_r[1]};
                res_nxt.weight_b = (k_r == 2'd1) ? w_nxt[k_r] : w_r[1];
              end
              if (n_r > NCNT_W'(2)) begin
                res_nxt.slot_c   = {1'b0, cs_r[2]};
                res_nxt.weight_c = (k_r == 2'd2) ? w_nxt[k_r] : w_r[2];
              end
              if (n_r > NCNT_W'(3)) begin
                res_nxt.slot_d   = {1'b0, cs_r[3]};
                res_nxt.weight_d = (k_r == 2'd3) ? w_nxt[k_r] : w_r[3];
              end
              fin_nxt   = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              k_nxt     = k_r + 2'd1;
              state_nxt = S_WPREP;
            end
          end
        end
      end

      S_WPREP: begin
        dv_num_nxt = NUM_W'(recip_r[k_r]) << 16;
        dv_den_nxt = total_r;
        dv_rem_nxt = '0;
        dv_q_nxt   = '0;
        dv_cnt_nxt = '0;
        state_nxt  = S_WDIV;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      limit_r     <= '0;
      n_r         <= '0;
      scan_r      <= '0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      count_r <= count_nxt;
      n_r     <= n_nxt;
      scan_r  <= scan_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      // a finished transaction moves to the output register when it is free
      if (fin_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    k_r       <= k_nxt;
    total_r   <= total_nxt;
    sq_src_r  <= sq_src_nxt;
    sq_rem_r  <= sq_rem_nxt;
    sq_root_r <= sq_root_nxt;
    sq_cnt_r  <= sq_cnt_nxt;
    dv_num_r  <= dv_num_nxt;
    dv_q_r    <= dv_q_nxt;
    dv_den_r  <= dv_den_nxt;
    dv_rem_r  <= dv_rem_nxt;
    dv_cnt_r  <= dv_cnt_nxt;
    for (int i = 0; i < NEAREST; i++) begin
      cd_r[i]    <= cd_nxt[i];
      cs_r[i]    <= cs_nxt[i];
      recip_r[i] <= recip_nxt[i];
      w_r[i]     <= w_nxt[i];
    end
    if (acc && (in_data.command == CMD_QUERY)) begin
      qx_r <= in_data.root_x;
      qy_r <= in_data.root_y;
      qz_r <= in_data.root_z;
      qg_r <= in_data.group_id;
    end
    if (fin_r && out_free) begin
      out_data_r <= res_r;
    end
  end

endmodule
